### sv/lrb_pkg.sv
// ----------------------------------------------------------------------------
// lrb_pkg: shared definitions for the link reconnect backoff supervisor
// Field widths, link state codes, register map and register reset values.
// ----------------------------------------------------------------------------
package lrb_pkg;

    // Default width of the millisecond time base.
    localparam int TIME_BITS_DEF = 32;

    // Width of every delay field and configuration register.
    localparam int DELAY_W = 24;

    // Link state codes as reported in the result item.
    localparam logic [1:0] ST_OFFLINE    = 2'd0;
    localparam logic [1:0] ST_CONNECTING = 2'd1;
    localparam logic [1:0] ST_ONLINE     = 2'd2;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_BACKOFF_START   = 2'd0;
    localparam logic [1:0] REG_BACKOFF_CAP     = 2'd1;
    localparam logic [1:0] REG_ATTEMPT_TIMEOUT = 2'd2;

    // Register reset values, milliseconds.
    localparam logic [DELAY_W-1:0] BACKOFF_START_RST   = 24'd1000;
    localparam logic [DELAY_W-1:0] BACKOFF_CAP_RST     = 24'd60000;
    localparam logic [DELAY_W-1:0] ATTEMPT_TIMEOUT_RST = 24'd10000;

    // Result item layout in m_tdata.
    localparam int OUT_FIELDS_W = 1 + 2 + 1 + 1 + DELAY_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

### sv/link_reconnect_backoff.sv
// ----------------------------------------------------------------------------
// link_reconnect_backoff: reconnect supervisor with exponential backoff
// A poll is held in the input register and its result in the result register.
// Throughput: one poll item per cycle while the result side takes an item each
// cycle; a stalled result holds the input register and then the input stream.
// The rate is set by the single decision stage, which reads and updates the
// supervisor state in the same cycle a poll moves into the result register.
// Reset (aresetn, synchronous, active low): both stages empty, state set to
// connecting with no attempt or retry armed, registers at their defaults.
// ----------------------------------------------------------------------------
module link_reconnect_backoff #(
    parameter int TIME_BITS = lrb_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Poll items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, lowest bit first: now_ms[TIME_BITS], link_up[1], zero fill
    input  logic [((TIME_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,

    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, lowest bit first: online[1], link_state[2], start_connect[1],
    // drop_connect[1], retry_delay_ms[24], zero fill
    output logic [lrb_pkg::OUT_TDATA_W-1:0]     m_tdata,

    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrb_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [lrb_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [lrb_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int DW    = lrb_pkg::DELAY_W;
    localparam int SUM_W = TIME_BITS + DW;
    localparam int PAD_W = lrb_pkg::OUT_TDATA_W - lrb_pkg::OUT_FIELDS_W;

    // ------------------------------------------------------------------
    // Configuration registers. The register index is paddr[3:2]; writes
    // to an index beyond the map are dropped and read back as zero.
    // ------------------------------------------------------------------
    logic [DW-1:0] backoff_start_reg;
    logic [DW-1:0] backoff_cap_reg;
    logic [DW-1:0] attempt_timeout_reg;
    logic          cfg_write;
    logic [1:0]    cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            backoff_start_reg   <= lrb_pkg::BACKOFF_START_RST;
            backoff_cap_reg     <= lrb_pkg::BACKOFF_CAP_RST;
            attempt_timeout_reg <= lrb_pkg::ATTEMPT_TIMEOUT_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                lrb_pkg::REG_BACKOFF_START:   backoff_start_reg   <= pwdata[DW-1:0];
                lrb_pkg::REG_BACKOFF_CAP:     backoff_cap_reg     <= pwdata[DW-1:0];
                lrb_pkg::REG_ATTEMPT_TIMEOUT: attempt_timeout_reg <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            lrb_pkg::REG_BACKOFF_START:
                prdata = {{(lrb_pkg::CFG_DATA_W - DW){1'b0}}, backoff_start_reg};
            lrb_pkg::REG_BACKOFF_CAP:
                prdata = {{(lrb_pkg::CFG_DATA_W - DW){1'b0}}, backoff_cap_reg};
            lrb_pkg::REG_ATTEMPT_TIMEOUT:
                prdata = {{(lrb_pkg::CFG_DATA_W - DW){1'b0}}, attempt_timeout_reg};
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage handshakes. The input register takes a new poll whenever it
    // is empty or its item moves on in the same cycle; the item moves on
    // whenever the result register is empty or being drained. This keeps
    // one item per cycle flowing while results are taken; a waiting result stalls it.
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    logic [TIME_BITS-1:0] in_now_reg;
    logic                 in_up_reg;
    logic                 m_valid_reg;
    logic                 out_ready;
    logic                 advance;
    logic                 s_accept;

    assign out_ready = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_now_reg <= s_tdata[TIME_BITS-1:0];
            in_up_reg  <= s_tdata[TIME_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Supervisor state.
    // ------------------------------------------------------------------
    logic [1:0]           status_reg,       status_next;
    logic                 attempt_active_reg, attempt_active_next;
    logic [DW-1:0]        backoff_reg,      backoff_next;
    logic [TIME_BITS-1:0] attempt_deadline_reg, attempt_deadline_next;
    logic [TIME_BITS-1:0] retry_deadline_reg,   retry_deadline_next;
    logic                 retry_armed_reg,  retry_armed_next;
    logic                 start_next;
    logic                 drop_next;

    // Deadlines are pending while (now - deadline) is negative, which
    // stays correct across a wrap of the time base.
    logic [TIME_BITS-1:0] attempt_diff;
    logic [TIME_BITS-1:0] retry_diff;
    logic                 attempt_pending;
    logic                 retry_pending;
    logic [DW:0]          backoff_twice;
    logic [DW-1:0]        backoff_grown;
    logic [SUM_W-1:0]     retry_sum;
    logic [SUM_W-1:0]     attempt_sum;

    assign attempt_diff    = in_now_reg - attempt_deadline_reg;
    assign retry_diff      = in_now_reg - retry_deadline_reg;
    assign attempt_pending = attempt_diff[TIME_BITS-1];
    assign retry_pending   = retry_diff[TIME_BITS-1];

    // First timeout uses the start value; later ones double, saturating
    // at the cap. A start above the cap is taken as given once.
    assign backoff_twice = {backoff_reg, 1'b0};
    always_comb begin
        if (backoff_reg == '0) begin
            backoff_grown = backoff_start_reg;
        end else if (backoff_twice > {1'b0, backoff_cap_reg}) begin
            backoff_grown = backoff_cap_reg;
        end else begin
            backoff_grown = backoff_twice[DW-1:0];
        end
    end

    assign retry_sum   = {{DW{1'b0}}, in_now_reg} + {{TIME_BITS{1'b0}}, backoff_grown};
    assign attempt_sum = {{DW{1'b0}}, in_now_reg}
                       + {{TIME_BITS{1'b0}}, attempt_timeout_reg};

    always_comb begin
        status_next           = status_reg;
        attempt_active_next   = attempt_active_reg;
        backoff_next          = backoff_reg;
        attempt_deadline_next = attempt_deadline_reg;
        retry_deadline_next   = retry_deadline_reg;
        retry_armed_next      = retry_armed_reg;
        start_next            = 1'b0;
        drop_next             = 1'b0;
        priority if (in_up_reg) begin
            // Link is up: online, backoff cleared, the retry deadline kept.
            attempt_active_next = 1'b0;
            backoff_next        = '0;
            status_next         = lrb_pkg::ST_ONLINE;
        end else if (attempt_active_reg && attempt_pending) begin
            status_next = lrb_pkg::ST_CONNECTING;
        end else if (attempt_active_reg) begin
            // Attempt timed out: abandon it and arm the retry deadline.
            drop_next           = 1'b1;
            attempt_active_next = 1'b0;
            backoff_next        = backoff_grown;
            retry_deadline_next = retry_sum[TIME_BITS-1:0];
            retry_armed_next    = 1'b1;
            status_next         = lrb_pkg::ST_OFFLINE;
        end else if (retry_armed_reg && retry_pending) begin
            status_next = lrb_pkg::ST_OFFLINE;
        end else begin
            // No retry pending (an unarmed retry counts as expired).
            start_next            = 1'b1;
            attempt_active_next   = 1'b1;
            attempt_deadline_next = attempt_sum[TIME_BITS-1:0];
            status_next           = lrb_pkg::ST_CONNECTING;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg         <= lrb_pkg::ST_CONNECTING;
            attempt_active_reg <= 1'b0;
            backoff_reg        <= '0;
            retry_deadline_reg <= '0;
            retry_armed_reg    <= 1'b0;
        end else if (advance) begin
            status_reg         <= status_next;
            attempt_active_reg <= attempt_active_next;
            backoff_reg        <= backoff_next;
            retry_deadline_reg <= retry_deadline_next;
            retry_armed_reg    <= retry_armed_next;
        end
    end

    // The attempt deadline is only read while an attempt is active, and
    // it is written together with that flag, so it needs no reset.
    always_ff @(posedge aclk) begin
        if (advance) begin
            attempt_deadline_reg <= attempt_deadline_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic [lrb_pkg::OUT_TDATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {{PAD_W{1'b0}}, backoff_next, drop_next, start_next,
                           status_next, in_up_reg};
        end
    end

    assign m_tdata = m_data_reg;

endmodule
